// File: rtl/assert_macros.svh
// assertion helpers used by the checker in pfbs_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, switched off while reset is high
`define PFBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked every clock, switched off while reset is high
`define PFBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication that also holds across reset
`define PFBS_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/pfbs_pkg.sv
package pfbs_pkg;

   // limits on the settings
   localparam int unsigned MAX_FRAMES      = 65535;
   localparam int unsigned MAX_INTERVAL_US = 1000000;
   localparam int unsigned US_PER_MS       = 1000;

   // field widths
   localparam int unsigned OP_W    = 3;
   localparam int unsigned IVL_W   = 20;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned MS_W    = 32;
   localparam int unsigned SUB_W   = 10;
   localparam int unsigned CSR_IDX_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_ARM     = 3'd0;
   localparam logic [OP_W-1:0] OP_ABORT   = 3'd1;
   localparam logic [OP_W-1:0] OP_MSG     = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
   localparam logic [OP_W-1:0] OP_TX_IDLE = 3'd4;

   // burst phases
   localparam logic [1:0] MODE_IDLE        = 2'd0;
   localparam logic [1:0] MODE_WAIT_READY  = 2'd1;
   localparam logic [1:0] MODE_WAIT_SETTLE = 2'd2;
   localparam logic [1:0] MODE_SENDING     = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_BUSY  = 2'd1;
   localparam logic [1:0] ERR_TX    = 2'd2;
   localparam logic [1:0] ERR_ABORT = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_US = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_MS   = 2'd2;

   // configuration reset values
   localparam logic [IVL_W-1:0] INTERVAL_US_RST = 20'd1000;
   localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 16'd1;
   localparam logic [CNT_W-1:0] SETTLE_MS_RST   = 16'd1000;

   // ready message recognition
   localparam logic [4:0] PS_RDY_TYPE = 5'd6;
   localparam logic [7:0] MIN_MSG_LEN = 8'd2;
   localparam logic [CNT_W-1:0] SLOTS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [IVL_W-1:0] pace_us;
      logic [CNT_W-1:0] frame_count;
      logic [CNT_W-1:0] settle_ms;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            sop_frame;
      logic [7:0]      msg_len;
      logic [7:0]      header_low;
      logic [7:0]      header_high;
      logic            link_active;
      logic            tx_busy;
      logic            tx_accepted;
   } req_item_type;

   typedef struct packed {
      logic             accepted;
      logic [1:0]       phase;
      logic             frame_sent;
      logic             done_res;
      logic             failed;
      logic [1:0]       error_code;
      logic [CNT_W-1:0] frames_sent;
      logic [MS_W-1:0]  duration_ms;
      logic [CNT_W-1:0] pending;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [CNT_W-1:0] frames_left;
      logic [CNT_W-1:0] frames_done;
      logic [CNT_W-1:0] slots_waiting;
      logic [IVL_W-1:0] interval_count;
      logic             pacer_running;
      logic [SUB_W-1:0] sub_ms_count;
      logic [MS_W-1:0]  now_ms;
      logic [MS_W-1:0]  settle_deadline;
      logic [MS_W-1:0]  start_ms;
      logic [MS_W-1:0]  elapsed_ms;
      logic             burst_begun;
      logic [1:0]       fault_code;
   } seq_state_type;

   // state plus the per-beat events
   typedef struct packed {
      seq_state_type st;
      logic          sent;
      logic          done;
      logic          fail;
   } step_type;

endpackage

// File: rtl/pfbs_if.sv
// request channel
interface pfbs_req_if;
   import pfbs_pkg::*;
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] op;
   logic            sop_frame;
   logic [7:0]      msg_len;
   logic [7:0]      header_low;
   logic [7:0]      header_high;
   logic            link_active;
   logic            tx_busy;
   logic            tx_accepted;

   modport source (output valid, op, sop_frame, msg_len, header_low, header_high,
                   link_active, tx_busy, tx_accepted, input ready);
   modport sink (input valid, op, sop_frame, msg_len, header_low, header_high,
                 link_active, tx_busy, tx_accepted, output ready);
   modport monitor (input valid, ready, op, sop_frame, msg_len, header_low,
                    header_high, link_active, tx_busy, tx_accepted);
endinterface

// response channel
interface pfbs_rsp_if;
   import pfbs_pkg::*;
   logic             valid;
   logic             ready;
   logic             accepted;
   logic [1:0]       phase;
   logic             frame_sent;
   logic             done_res;
   logic             failed;
   logic [1:0]       error_code;
   logic [CNT_W-1:0] frames_sent;
   logic [MS_W-1:0]  duration_ms;
   logic [CNT_W-1:0] pending;

   modport source (output valid, accepted, phase, frame_sent, done_res, failed,
                   error_code, frames_sent, duration_ms, pending, input ready);
   modport sink (input valid, accepted, phase, frame_sent, done_res, failed,
                 error_code, frames_sent, duration_ms, pending, output ready);
   modport monitor (input valid, ready, accepted, phase, frame_sent, done_res,
                    failed, error_code, frames_sent, duration_ms, pending);
endinterface

// File: rtl/pfbs_csr.sv
module pfbs_csr
   import pfbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IVL_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pace_us     <= INTERVAL_US_RST;
         cfg_ff.frame_count <= FRAME_COUNT_RST;
         cfg_ff.settle_ms   <= SETTLE_MS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INTERVAL_US: cfg_ff.pace_us     <= csr_wdata;
            CSR_FRAME_COUNT: cfg_ff.frame_count <= csr_wdata[CNT_W-1:0];
            CSR_SETTLE_MS:   cfg_ff.settle_ms   <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pfbs_in_stage.sv
module pfbs_in_stage
   import pfbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pfbs_req_if.sink      req_bus,
   input  logic          advance,
   output logic          item_valid,
   output req_item_type  item
);

   logic         valid_ff;
   logic         valid_in;
   logic         take;
   req_item_type item_ff;

   // free slot or the held beat moves on this cycle
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;
   assign valid_in      = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.op          <= req_bus.op;
         item_ff.sop_frame   <= req_bus.sop_frame;
         item_ff.msg_len     <= req_bus.msg_len;
         item_ff.header_low  <= req_bus.header_low;
         item_ff.header_high <= req_bus.header_high;
         item_ff.link_active <= req_bus.link_active;
         item_ff.tx_busy     <= req_bus.tx_busy;
         item_ff.tx_accepted <= req_bus.tx_accepted;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/pfbs_step_core.sv
module pfbs_step_core
   import pfbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   seq_state_type state_ff;
   seq_state_type state_in;

   // error a send would hit, none when it would go out
   function automatic logic [1:0] send_err(logic link, logic busy, logic txacc);
      logic [1:0] e;
      if (!link) begin
         e = ERR_ABORT;
      end else if (busy) begin
         e = ERR_BUSY;
      end else if (!txacc) begin
         e = ERR_TX;
      end else begin
         e = ERR_NONE;
      end
      return e;
   endfunction

   // end of burst, success or error
   function automatic step_type finish(step_type s, logic ok, logic [1:0] err);
      step_type r;
      r = s;
      r.st.pacer_running  = 1'b0;
      r.st.interval_count = '0;
      r.st.slots_waiting  = '0;
      if (r.st.burst_begun && (r.st.elapsed_ms == '0)) begin
         r.st.elapsed_ms = r.st.now_ms - r.st.start_ms;
      end
      r.st.mode        = MODE_IDLE;
      r.st.burst_begun = 1'b0;
      r.st.fault_code  = err;
      r.st.frames_left = '0;
      if (ok) begin
         r.done = 1'b1;
      end else begin
         r.fail = 1'b1;
      end
      return r;
   endfunction

   // clear all burst bookkeeping
   function automatic step_type clear_burst(step_type s);
      step_type r;
      r = s;
      r.st.pacer_running   = 1'b0;
      r.st.interval_count  = '0;
      r.st.mode            = MODE_IDLE;
      r.st.frames_left     = '0;
      r.st.frames_done     = '0;
      r.st.settle_deadline = '0;
      r.st.start_ms        = '0;
      r.st.elapsed_ms      = '0;
      r.st.fault_code      = ERR_NONE;
      r.st.burst_begun     = 1'b0;
      r.st.slots_waiting   = '0;
      return r;
   endfunction

   // send one pending slot; bus busy just defers it
   function automatic step_type drain_one(step_type s, logic [1:0] e);
      step_type r;
      r = s;
      if ((r.st.slots_waiting != '0) && (r.st.mode == MODE_SENDING)) begin
         if ((r.st.frames_left != '0) && (e != ERR_NONE)) begin
            if (e != ERR_BUSY) begin
               r = finish(r, 1'b0, e);
            end
         end else begin
            if (r.st.frames_left != '0) begin
               r.st.frames_left = r.st.frames_left - 1'b1;
               r.st.frames_done = r.st.frames_done + 1'b1;
               r.sent           = 1'b1;
            end
            r.st.slots_waiting = r.st.slots_waiting - 1'b1;
            if (r.st.frames_left == '0) begin
               r.st.elapsed_ms = r.st.now_ms - r.st.start_ms;
               r = finish(r, 1'b1, ERR_NONE);
            end
         end
      end
      return r;
   endfunction

   // first frame goes out at once, any failure ends the burst
   function automatic step_type begin_burst(step_type s, logic [1:0] e);
      step_type r;
      r = s;
      r.st.burst_begun = 1'b1;
      r.st.start_ms    = r.st.now_ms;
      r.st.elapsed_ms  = '0;
      if ((r.st.frames_left != '0) && (e != ERR_NONE)) begin
         r = finish(r, 1'b0, e);
      end else begin
         if (r.st.frames_left != '0) begin
            r.st.frames_left = r.st.frames_left - 1'b1;
            r.st.frames_done = r.st.frames_done + 1'b1;
            r.sent           = 1'b1;
         end
         if (r.st.frames_left == '0) begin
            r = finish(r, 1'b1, ERR_NONE);
         end else begin
            r.st.interval_count = '0;
            r.st.pacer_running  = 1'b1;
         end
      end
      return r;
   endfunction

   step_type         s;
   logic [1:0]       tx_err;
   logic             arm_ok;
   logic             accepted;
   logic             ready_msg;
   logic [SUB_W:0]   sub_inc;
   logic [MS_W-1:0]  settle_diff;

   assign tx_err = send_err(item.link_active, item.tx_busy, item.tx_accepted);

   // settings check for arm
   assign arm_ok = (cfg.pace_us != '0)
                && ({12'd0, cfg.pace_us} <= MS_W'(MAX_INTERVAL_US))
                && (cfg.frame_count != '0)
                && ({16'd0, cfg.frame_count} <= MS_W'(MAX_FRAMES));

   // plain sop, not extended, ps_rdy type, long enough
   assign ready_msg = item.sop_frame && (item.msg_len >= MIN_MSG_LEN)
                   && !item.header_high[7] && (item.header_low[4:0] == PS_RDY_TYPE);

   // one item's effect on the sequencer state
   always_comb begin
      s           = '0;
      s.st        = state_ff;
      accepted    = 1'b0;
      sub_inc     = '0;
      settle_diff = '0;
      unique case (item.op)
         OP_ARM: begin
            if (arm_ok && (s.st.mode == MODE_IDLE)) begin
               s = clear_burst(s);
               s.st.frames_left = cfg.frame_count;
               s.st.mode        = MODE_WAIT_READY;
               accepted         = 1'b1;
            end
         end
         OP_ABORT: begin
            if (s.st.mode == MODE_IDLE) begin
               s = clear_burst(s);
            end else begin
               if ((s.st.mode == MODE_SENDING) && s.st.burst_begun) begin
                  s.st.elapsed_ms = s.st.now_ms - s.st.start_ms;
               end
               s = finish(s, 1'b0, ERR_ABORT);
            end
         end
         OP_MSG: begin
            if ((s.st.mode == MODE_WAIT_READY) && ready_msg) begin
               s.st.mode            = MODE_WAIT_SETTLE;
               s.st.settle_deadline = s.st.now_ms + {16'd0, cfg.settle_ms};
            end
         end
         OP_TICK: begin
            // millisecond clock
            sub_inc = {1'b0, s.st.sub_ms_count} + 1'b1;
            if (sub_inc >= (SUB_W+1)'(US_PER_MS)) begin
               s.st.sub_ms_count = '0;
               s.st.now_ms       = s.st.now_ms + 1'b1;
            end else begin
               s.st.sub_ms_count = sub_inc[SUB_W-1:0];
            end
            // pacer expiry adds a slot and tries to send
            if (s.st.pacer_running) begin
               s.st.interval_count = s.st.interval_count + 1'b1;
               if (s.st.interval_count >= cfg.pace_us) begin
                  s.st.interval_count = '0;
                  if (s.st.mode == MODE_SENDING) begin
                     if (s.st.slots_waiting != SLOTS_MAX) begin
                        s.st.slots_waiting = s.st.slots_waiting + 1'b1;
                     end
                     s = drain_one(s, tx_err);
                  end
               end
            end
            // settle wait over, wrap-safe compare
            settle_diff = s.st.now_ms - s.st.settle_deadline;
            if ((s.st.mode == MODE_WAIT_SETTLE) && !settle_diff[MS_W-1]) begin
               s.st.mode = MODE_SENDING;
            end
            if ((s.st.mode == MODE_SENDING) && !s.st.burst_begun) begin
               s = begin_burst(s, tx_err);
            end
         end
         OP_TX_IDLE: begin
            if ((s.st.mode == MODE_SENDING) && s.st.burst_begun) begin
               s = drain_one(s, tx_err);
            end
         end
         default: begin
         end
      endcase
   end

   assign state_in = s.st;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result of this beat
   always_comb begin
      result.accepted    = accepted;
      result.phase       = s.st.mode;
      result.frame_sent  = s.sent;
      result.done_res    = s.done;
      result.failed      = s.fail;
      result.error_code  = s.st.fault_code;
      result.frames_sent = s.st.frames_done;
      result.duration_ms = s.st.elapsed_ms;
      result.pending     = s.st.slots_waiting;
   end

endmodule

// File: rtl/pfbs_out_stage.sv
module pfbs_out_stage
   import pfbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  rsp_item_type result,
   output logic         advance,
   pfbs_rsp_if.source   rsp_bus
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   // result register frees up when empty or being taken
   assign advance  = item_valid && (!valid_ff || rsp_bus.ready);
   assign valid_in = advance || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   // drive the response beat
   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.accepted    = result_ff.accepted;
   assign rsp_bus.phase       = result_ff.phase;
   assign rsp_bus.frame_sent  = result_ff.frame_sent;
   assign rsp_bus.done_res    = result_ff.done_res;
   assign rsp_bus.failed      = result_ff.failed;
   assign rsp_bus.error_code  = result_ff.error_code;
   assign rsp_bus.frames_sent = result_ff.frames_sent;
   assign rsp_bus.duration_ms = result_ff.duration_ms;
   assign rsp_bus.pending     = result_ff.pending;

endmodule

// File: rtl/paced_frame_burst_sequencer_top.sv
// Paced frame burst sequencer.
// req_bus carries one event per beat: arm, abort, received message,
// microsecond tick or transmitter idle, with the link and transmitter status
// sampled for that event. rsp_bus returns exactly one beat per request beat,
// in order: arm accepted, phase, frame sent, done or failed, error code,
// frames sent, burst duration in ms and pending paced slots.
// csr_we/csr_index/csr_wdata write the pacing period in us, frame_count and
// settle_ms; write them only while no request is in flight.
// Throughput is one beat per cycle while rsp_bus.ready stays high. A request
// passes through an input register, then the combinational step logic into
// the response register.
// Reset (synchronous, active high) returns to idle, clears the ms clock and
// the burst bookkeeping and loads the register defaults; no response is
// pending afterward. When the receiver holds rsp_bus.ready low the response
// stays put, one more request is still taken into the input register, and
// req_bus.ready then drops until the response moves.
module paced_frame_burst_sequencer_top
   import pfbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pfbs_req_if.sink             req_bus,
   pfbs_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IVL_W-1:0]     csr_wdata
);

   cfg_type      cfg;
   req_item_type item;
   logic         item_valid;
   logic         advance;
   rsp_item_type result;

   pfbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pfbs_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pfbs_step_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .result  (result)
   );

   pfbs_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: rtl/pfbs_checker.sv
`include "assert_macros.svh"

module pfbs_checker
   import pfbs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_accepted,
   input logic [1:0]       rsp_phase,
   input logic             rsp_frame_sent,
   input logic             rsp_done_res,
   input logic             rsp_failed,
   input logic [1:0]       rsp_error_code,
   input logic [CNT_W-1:0] rsp_frames_sent,
   input logic [MS_W-1:0]  rsp_duration_ms,
   input logic [CNT_W-1:0] rsp_pending
);

   logic                   stall;
   logic [1+CNT_W+MS_W:0]  rsp_view;
   logic                   burst_end;
   logic                   idle_clear;
   logic                   arm_seen;
   logic                   arm_clean;
   logic                   mid_send;

   assign stall      = rsp_valid && !rsp_ready;
   assign rsp_view   = {rsp_phase, rsp_frames_sent, rsp_duration_ms};
   assign burst_end  = rsp_valid && (rsp_done_res || rsp_failed);
   assign idle_clear = (rsp_phase == MODE_IDLE) && (rsp_pending == '0)
                    && !(rsp_done_res && rsp_failed);
   assign arm_seen   = rsp_valid && rsp_accepted;
   assign arm_clean  = (rsp_phase == MODE_WAIT_READY) && (rsp_frames_sent == '0)
                    && (rsp_error_code == ERR_NONE) && (rsp_duration_ms == '0);
   assign mid_send   = rsp_valid && rsp_frame_sent && !rsp_done_res;

   // no response is left over from before reset
   `PFBS_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset), !rsp_valid)

   // stalled response beat stays valid and holds its phase, frames sent and duration
   `PFBS_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_valid && $stable(rsp_view))

   // a finished burst leaves the block idle with nothing pending
   `PFBS_ASSERT_IMPL(a_finish_idle, clock, reset, burst_end, idle_clear)

   // an accepted arm starts a clean burst waiting for the ready message
   `PFBS_ASSERT_IMPL(a_arm_clean, clock, reset, arm_seen, arm_clean)

   // a frame sent without ending the burst happens only while sending
   `PFBS_ASSERT_IMPL(a_sent_phase, clock, reset, mid_send, rsp_phase == MODE_SENDING)

endmodule

bind paced_frame_burst_sequencer_top pfbs_checker u_pfbs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_accepted    (rsp_bus.accepted),
   .rsp_phase       (rsp_bus.phase),
   .rsp_frame_sent  (rsp_bus.frame_sent),
   .rsp_done_res    (rsp_bus.done_res),
   .rsp_failed      (rsp_bus.failed),
   .rsp_error_code  (rsp_bus.error_code),
   .rsp_frames_sent (rsp_bus.frames_sent),
   .rsp_duration_ms (rsp_bus.duration_ms),
   .rsp_pending     (rsp_bus.pending)
);
